// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Default depth of the queue
    localparam int DEFAULT_CAPACITY = 16;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Request kinds carried in tuser
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd2;

    // One stored entry
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } t_entry;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry item;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One cell of the sorted queue chain: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
    parameter bit FIRST = 1'b0
) (
    input  wire logic           i_clk,
    input  wire spq_pkg::t_ctrl i_ctrl,
    input  wire logic           i_valid,       // this cell holds an entry
    input  wire logic           i_left_valid,  // left neighbor holds an entry
    input  wire logic           i_left_shift,  // left neighbor moves right on push
    input  wire spq_pkg::t_entry i_left_entry,
    input  wire spq_pkg::t_entry i_right_entry,
    output spq_pkg::t_entry     o_entry,
    output logic                o_shift
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            w_behind;

    // The head yields only to a strictly smaller priority, others to equal too
    always_comb begin
        if (FIRST) begin
            w_behind = r_entry.prio > i_ctrl.item.prio;
        end else begin
            w_behind = r_entry.prio >= i_ctrl.item.prio;
        end
    end

    assign o_shift = i_valid && w_behind;
    assign o_entry = r_entry;

    // Pick the next entry: shift in from the left, take the new item, or pull from the right
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.push) begin
            if (i_left_shift) begin
                n_entry = i_left_entry;
            end else if ((o_shift || !i_valid) && i_left_valid) begin
                n_entry = i_ctrl.item;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain, count and result register.
// The result of an accepted request is registered and appears in the cycle after acceptance.
// Throughput: 1 request per cycle while the result output is not stalled; every cell compares and moves in parallel,
// so one update of the cell chain per cycle sets the rate.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// stored entries are not cleared and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // [31:0] item_value, [47:32] item_priority
    input  wire logic        s_axis_tuser,   // [0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata    // [31:0] removed_value, [63:32] head_value,
                                             // [79:64] head_priority, [84:80] entry_count,
                                             // [85] is_empty, [86] is_full,
                                             // [88:87] status, [95:89] zero
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    logic [95:0]       r_out_data;
    logic [95:0]       n_out_data;

    spq_pkg::t_ctrl    w_ctrl;
    spq_pkg::t_entry   w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_shift;
    logic [CAPACITY-1:0] w_valid;

    logic              w_accept;
    logic              w_empty;
    logic              w_full;
    logic              w_do_push;
    logic              w_do_pop;
    spq_pkg::t_entry   w_item;
    logic signed [spq_pkg::VALUE_W-1:0] w_removed;
    spq_pkg::t_entry   w_head;
    logic [spq_pkg::STATUS_W-1:0] w_status;
    logic [31:0]       w_count_ext;
    logic              w_next_empty;
    logic              w_next_full;

    // Accept a request whenever the result slot is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_item.value = s_axis_tdata[31:0];
    assign w_item.prio  = s_axis_tdata[47:32];

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_do_push = w_accept && (s_axis_tuser == spq_pkg::MODE_PUSH) && !w_full;
    assign w_do_pop  = w_accept && (s_axis_tuser == spq_pkg::MODE_POP) && !w_empty;

    assign w_ctrl.push = w_do_push;
    assign w_ctrl.pop  = w_do_pop;
    assign w_ctrl.item = w_item;

    // Build the chain of cells
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        assign w_valid[k] = (r_count > CW'(k));

        if (k == 0) begin : g_head
            spq_cell #(
                .FIRST(1'b1)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_valid       (w_valid[k]),
                .i_left_valid  (1'b1),
                .i_left_shift  (1'b0),
                .i_left_entry  (w_item),
                .i_right_entry (w_entry[(k + 1) % CAPACITY]),
                .o_entry       (w_entry[k]),
                .o_shift       (w_shift[k])
            );
        end else if (k == CAPACITY - 1) begin : g_tail
            spq_cell #(
                .FIRST(1'b0)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_valid       (w_valid[k]),
                .i_left_valid  (w_valid[k-1]),
                .i_left_shift  (w_shift[k-1]),
                .i_left_entry  (w_entry[k-1]),
                .i_right_entry (w_entry[k]),
                .o_entry       (w_entry[k]),
                .o_shift       (w_shift[k])
            );
        end else begin : g_mid
            spq_cell #(
                .FIRST(1'b0)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_valid       (w_valid[k]),
                .i_left_valid  (w_valid[k-1]),
                .i_left_shift  (w_shift[k-1]),
                .i_left_entry  (w_entry[k-1]),
                .i_right_entry (w_entry[k+1]),
                .o_entry       (w_entry[k]),
                .o_shift       (w_shift[k])
            );
        end
    end

    // Advance the count
    always_comb begin
        n_count = r_count;
        if (w_do_push) begin
            n_count = r_count + CW'(1);
        end else if (w_do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // Work out the head after the operation
    always_comb begin
        w_head = w_entry[0];
        if (w_do_push) begin
            if (w_shift[0] || !w_valid[0]) begin
                w_head = w_item;
            end
        end else if (w_do_pop) begin
            w_head = w_entry[1];
        end
        if (n_count == '0) begin
            w_head = '0;
        end
    end

    // Status and removed data
    always_comb begin
        w_status  = spq_pkg::STATUS_OK;
        w_removed = '0;
        if (s_axis_tuser == spq_pkg::MODE_PUSH) begin
            if (w_full) begin
                w_status = spq_pkg::STATUS_PUSH_FULL;
            end
        end else begin
            if (w_empty) begin
                w_status = spq_pkg::STATUS_POP_EMPTY;
            end else begin
                w_removed = w_entry[0].value;
            end
        end
    end

    assign w_count_ext  = 32'(n_count);
    assign w_next_empty = (n_count == '0);
    assign w_next_full  = (n_count == CW'(CAPACITY));

    // Pack the result
    always_comb begin
        n_out_data        = '0;
        n_out_data[31:0]  = w_removed;
        n_out_data[63:32] = w_head.value;
        n_out_data[79:64] = w_head.prio;
        n_out_data[84:80] = w_count_ext[4:0];
        n_out_data[85]    = w_next_empty;
        n_out_data[86]    = w_next_full;
        n_out_data[88:87] = w_status;
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the sorted priority queue: stream requests in, results predicted.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    localparam int QUEUE_DEPTH  = spq_pkg::DEFAULT_CAPACITY;
    localparam int VALUE_W      = spq_pkg::VALUE_W;
    localparam int PRIO_W       = spq_pkg::PRIO_W;
    localparam int COUNT_W      = spq_pkg::COUNT_W;
    localparam int STATUS_W     = spq_pkg::STATUS_W;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int IDLE_PERCENT = 17;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_CYCLES  = 400;

    // One result as the block reports it
    typedef struct packed {
        logic signed [VALUE_W-1:0] removed_value;
        logic signed [VALUE_W-1:0] head_value;
        logic [PRIO_W-1:0]         head_priority;
        logic [COUNT_W-1:0]        entry_count;
        logic                      is_empty;
        logic                      is_full;
        logic [STATUS_W-1:0]       status;
    } t_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;    // [31:0] item_value, [47:32] item_priority
    logic        s_axis_tuser  = spq_pkg::MODE_PUSH;    // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;          // [31:0] removed_value, [63:32] head_value,
                                        // [79:64] head_priority, [84:80] entry_count,
                                        // [85] is_empty, [86] is_full, [88:87] status

    // Shadow copy of the queue contents, head at index 0
    logic signed [VALUE_W-1:0] shadow_value [QUEUE_DEPTH];
    logic [PRIO_W-1:0]         shadow_prio  [QUEUE_DEPTH];
    int unsigned               shadow_len = 0;

    // Results predicted but not yet seen at the output
    t_result     awaited_results [$];

    bit          calm           = 1'b0;
    bit          hold_start     = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned push_total     = 0;
    int unsigned pop_total      = 0;
    int unsigned full_rejects   = 0;
    int unsigned empty_rejects  = 0;
    int unsigned peak_len       = 0;

    always #5 i_clk = ~i_clk;

    sorted_priority_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Apply one request to the shadow queue and work out the result it causes
    task automatic apply_request(input logic mode, input logic signed [VALUE_W-1:0] value,
                                 input logic [PRIO_W-1:0] prio, output t_result res);
        int unsigned pos;
        int unsigned k;
        res = '0;
        res.status = spq_pkg::STATUS_OK;
        if (mode == spq_pkg::MODE_PUSH) begin
            if (shadow_len >= QUEUE_DEPTH) begin
                res.status = spq_pkg::STATUS_PUSH_FULL;
            end else begin
                // head yields only to a strictly lower number, later slots also to an equal one
                if (shadow_len == 0 || shadow_prio[0] > prio) begin
                    pos = 0;
                end else begin
                    pos = 1;
                    while (pos < shadow_len && shadow_prio[pos] < prio) pos++;
                end
                for (k = shadow_len; k > pos; k--) begin
                    shadow_value[k] = shadow_value[k-1];
                    shadow_prio[k]  = shadow_prio[k-1];
                end
                shadow_value[pos] = value;
                shadow_prio[pos]  = prio;
                shadow_len++;
            end
        end else begin
            if (shadow_len == 0) begin
                res.status = spq_pkg::STATUS_POP_EMPTY;
            end else begin
                res.removed_value = shadow_value[0];
                for (k = 1; k < shadow_len; k++) begin
                    shadow_value[k-1] = shadow_value[k];
                    shadow_prio[k-1]  = shadow_prio[k];
                end
                shadow_len--;
            end
        end
        if (shadow_len != 0) begin
            res.head_value    = shadow_value[0];
            res.head_priority = shadow_prio[0];
        end
        res.entry_count = shadow_len[COUNT_W-1:0];
        res.is_empty    = (shadow_len == 0);
        res.is_full     = (shadow_len == QUEUE_DEPTH);
    endtask

    // Offer one request, with a random gap first unless in a calm stretch, and record its result once accepted
    task automatic send_request(input logic mode, input logic [VALUE_W-1:0] value,
                                input logic [PRIO_W-1:0] prio);
        t_result res;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {prio, value};
        s_axis_tuser  <= mode;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        apply_request(mode, value, prio, res);
        awaited_results.push_back(res);
        if (mode == spq_pkg::MODE_PUSH) begin
            push_total++;
            if (res.status == spq_pkg::STATUS_PUSH_FULL) full_rejects++;
        end else begin
            pop_total++;
            if (res.status == spq_pkg::STATUS_POP_EMPTY) empty_rejects++;
        end
        if (shadow_len > peak_len) peak_len = shadow_len;
    endtask

    // Often one of few distinct priorities so that ties are common, plus extremes and full range
    function automatic logic [PRIO_W-1:0] pick_priority();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return PRIO_W'($urandom_range(0, 3));
        if (roll < 50) return ($urandom_range(0, 1) != 0) ? {PRIO_W{1'b1}} : {PRIO_W{1'b0}};
        return PRIO_W'($urandom);
    endfunction

    task automatic send_random(input int unsigned push_percent);
        logic mode;
        mode = ($urandom_range(0, 99) < push_percent) ? spq_pkg::MODE_PUSH : spq_pkg::MODE_POP;
        send_request(mode, VALUE_W'($urandom), pick_priority());
    endtask

    // Drop the request line and wait until every predicted result has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic string format_result(input t_result r);
        return $sformatf("rm=%h hv=%h hp=%h n=%0d e=%b f=%b st=%0d", r.removed_value,
                         r.head_value, r.head_priority, r.entry_count, r.is_empty,
                         r.is_full, r.status);
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endtask

    // Compare one output word with the oldest prediction
    task automatic check_result(input logic [95:0] word);
        t_result got;
        t_result want;
        string   wrong;
        got.removed_value = word[31:0];
        got.head_value    = word[63:32];
        got.head_priority = word[79:64];
        got.entry_count   = word[84:80];
        got.is_empty      = word[85];
        got.is_full       = word[86];
        got.status        = word[88:87];
        results_seen++;
        if (awaited_results.size() == 0) begin
            note_failure({"result with nothing awaited: ", format_result(got)});
            return;
        end
        want  = awaited_results.pop_front();
        wrong = "";
        if (got.removed_value !== want.removed_value) wrong = {wrong, " removed_value"};
        if (got.head_value !== want.head_value)       wrong = {wrong, " head_value"};
        if (got.head_priority !== want.head_priority) wrong = {wrong, " head_priority"};
        if (got.entry_count !== want.entry_count)     wrong = {wrong, " entry_count"};
        if (got.is_empty !== want.is_empty)           wrong = {wrong, " is_empty"};
        if (got.is_full !== want.is_full)             wrong = {wrong, " is_full"};
        if (got.status !== want.status)               wrong = {wrong, " status"};
        if (word[95:89] !== '0)                       wrong = {wrong, " padding"};
        if (wrong != "") begin
            note_failure($sformatf("result %0d:%s; expected %s, got %s", results_seen, wrong,
                                   format_result(want), format_result(got)));
        end
    endtask

    // Output side: check accepted results, then choose the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
        if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Empty pops, push into empty, ties at head, middle and tail, extreme values
    task automatic test_directed_ordering();
        int unsigned i;
        send_request(spq_pkg::MODE_POP, 32'h0000_0000, 16'h0000);
        send_request(spq_pkg::MODE_POP, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(spq_pkg::MODE_PUSH, 32'd100, 16'd1000);
        send_request(spq_pkg::MODE_PUSH, 32'h8000_0000, 16'd1000);
        send_request(spq_pkg::MODE_PUSH, 32'h7FFF_FFFF, 16'd999);
        send_request(spq_pkg::MODE_PUSH, 32'h0000_0000, 16'h0000);
        send_request(spq_pkg::MODE_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(spq_pkg::MODE_PUSH, 32'd7, 16'd1000);
        send_request(spq_pkg::MODE_PUSH, 32'd8, 16'hFFFF);
        send_request(spq_pkg::MODE_PUSH, 32'd9, 16'h0000);
        send_request(spq_pkg::MODE_PUSH, 32'h5555_AAAA, 16'h5A5A);
        for (i = 0; i < 9; i++) send_request(spq_pkg::MODE_POP, 32'hA5A5_5A5A, 16'hA5A5);
        send_request(spq_pkg::MODE_POP, 32'h1234_5678, 16'h0001);
    endtask

    // Fill, push against full, part drain, refill, drain to empty and beyond
    task automatic test_full_boundary();
        int unsigned i;
        while (shadow_len < QUEUE_DEPTH) send_random(100);
        send_request(spq_pkg::MODE_PUSH, VALUE_W'($urandom), 16'h0000);
        send_request(spq_pkg::MODE_PUSH, VALUE_W'($urandom), 16'hFFFF);
        for (i = 0; i < 3; i++) send_random(0);
        while (shadow_len < QUEUE_DEPTH) send_random(100);
        send_random(100);
        while (shadow_len > 0) send_random(0);
        send_random(0);
    endtask

    // Phases that lean toward filling, draining, or neither, so the count sweeps its range
    task automatic test_random_phases(input int unsigned count);
        int unsigned sent;
        int unsigned span;
        int unsigned push_percent;
        int unsigned i;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 2))
                0: begin
                    push_percent = 85;
                end
                1: begin
                    push_percent = 15;
                end
                default: begin
                    push_percent = 50;
                end
            endcase
            span = $urandom_range(10, 60);
            for (i = 0; i < span && sent < count; i++) begin
                send_random(push_percent);
                sent++;
            end
        end
    endtask

    // Back-to-back traffic with neither side idling
    task automatic test_calm_stretch(input int unsigned count);
        int unsigned i;
        calm = 1'b1;
        for (i = 0; i < count; i++) send_random(i < count / 2 ? 70 : 35);
        calm = 1'b0;
    endtask

    // Hold the output off for a long time while requests keep coming
    task automatic test_output_backpressure(input int unsigned count);
        int unsigned i;
        hold_start = 1'b1;
        for (i = 0; i < count; i++) send_random(55);
    endtask

    // Pause the input after every few requests until all results are back
    task automatic test_drain_pause(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++) begin
            send_random(50);
            if (i % 12 == 11) wait_drained();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_ordering();
        test_full_boundary();
        test_random_phases(1150);
        test_calm_stretch(300);
        test_output_backpressure(60);
        test_drain_pause(60);
        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("covered %0d pushes (%0d refused as full) and %0d pops (%0d refused as empty)",
                 push_total, full_rejects, pop_total, empty_rejects);
        $display("deepest fill %0d of %0d, %0d results checked, %0d mismatches",
                 peak_len, QUEUE_DEPTH, results_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
